// ===== hw/rtl/m3i_pkg.sv =====
package m3i_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ENTRY_WIDTH = 32;
   localparam int FIELD_W     = 32;
   localparam int DETQ_W      = 64;
   localparam int EPS_W       = 32;

   // exact product, cofactor and determinant widths
   localparam int PROD_W    = 2 * ENTRY_WIDTH;
   localparam int COF_W     = PROD_W + 1;
   localparam int COF_LO_W  = ENTRY_WIDTH + 1;
   localparam int COF_HI_W  = COF_W - COF_LO_W;
   localparam int LO_PROD_W = ENTRY_WIDTH + COF_LO_W + 1;
   localparam int HI_PROD_W = ENTRY_WIDTH + COF_HI_W;
   localparam int TERM_W    = ENTRY_WIDTH + COF_W;
   localparam int DET_W     = TERM_W + 2;

   // determinant to Q32.32
   localparam int DQ_SHIFT = 3 * FRAC_BITS - 32;
   localparam int SH_R     = (DQ_SHIFT > 0) ? DQ_SHIFT : 0;
   localparam int SH_L     = (DQ_SHIFT > 0) ? 0 : -DQ_SHIFT;
   localparam int DQ_W     = (DET_W + SH_L + 1 > DETQ_W + 1) ? DET_W + SH_L + 1 : DETQ_W + 1;

   // divider
   localparam int MAG_W  = COF_W - 1;
   localparam int NUM_SH = 2 * FRAC_BITS + 1;
   localparam int DD_W   = DET_W + 1;
   localparam int NUM_W  = ((MAG_W + NUM_SH > DET_W) ? MAG_W + NUM_SH : DET_W) + 1;
   localparam int QB     = ENTRY_WIDTH + 1;

   // pipeline
   localparam int COF_DLY  = 4;
   localparam int SING_DLY = QB + 2;
   localparam int LATENCY  = QB + 10;

   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] ADDR_EPS  = '0;
   localparam logic [EPS_W-1:0]  EPS_RESET = 32'd4295;

   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;
   typedef logic signed [COF_W-1:0]       cof_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] a00;
      logic signed [FIELD_W-1:0] a01;
      logic signed [FIELD_W-1:0] a02;
      logic signed [FIELD_W-1:0] a10;
      logic signed [FIELD_W-1:0] a11;
      logic signed [FIELD_W-1:0] a12;
      logic signed [FIELD_W-1:0] a20;
      logic signed [FIELD_W-1:0] a21;
      logic signed [FIELD_W-1:0] a22;
   } req_word_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] inv_00;
      logic signed [FIELD_W-1:0] inv_01;
      logic signed [FIELD_W-1:0] inv_02;
      logic signed [FIELD_W-1:0] inv_10;
      logic signed [FIELD_W-1:0] inv_11;
      logic signed [FIELD_W-1:0] inv_12;
      logic signed [FIELD_W-1:0] inv_20;
      logic signed [FIELD_W-1:0] inv_21;
      logic signed [FIELD_W-1:0] inv_22;
      logic signed [DETQ_W-1:0]  determinant;
      logic                      singular;
   } rsp_word_type;

   typedef struct packed {
      logic [DET_W-1:0] dabs;
      logic             neg;
   } det_info_type;

endpackage

// ===== hw/rtl/m3i_cofactor.sv =====
module m3i_cofactor (
   input  logic                clock,
   input  logic                adv,
   input  m3i_pkg::entry_type  x0,
   input  m3i_pkg::entry_type  x1,
   input  m3i_pkg::entry_type  y0,
   input  m3i_pkg::entry_type  y1,
   input  logic                flip,
   output m3i_pkg::cof_type    cof
);

   logic signed [m3i_pkg::PROD_W-1:0] p_ff, p_in, q_ff, q_in;
   m3i_pkg::cof_type                  diff;
   m3i_pkg::cof_type                  cof_ff, cof_in;

   assign p_in = x0 * x1;
   assign q_in = y0 * y1;

   // signed minor, negated for odd row+column
   assign diff   = m3i_pkg::COF_W'(p_ff) - m3i_pkg::COF_W'(q_ff);
   assign cof_in = flip ? -diff : diff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff   <= p_in;
         q_ff   <= q_in;
         cof_ff <= cof_in;
      end
   end

   assign cof = cof_ff;

endmodule

// ===== hw/rtl/m3i_det.sv =====
module m3i_det (
   input  logic                          clock,
   input  logic                          adv,
   input  m3i_pkg::entry_type            col0 [3],
   input  m3i_pkg::cof_type              cof0 [3],
   input  logic [m3i_pkg::EPS_W-1:0]     eps,
   output m3i_pkg::det_info_type         info,
   output logic signed [m3i_pkg::DETQ_W-1:0] detq,
   output logic                          sing
);

   localparam logic signed [m3i_pkg::DQ_W-1:0] DQ_HALF =
      (m3i_pkg::DQ_W'(1) << m3i_pkg::SH_R) >> 1;

   logic signed [m3i_pkg::LO_PROD_W-1:0] lo_ff [3];
   logic signed [m3i_pkg::HI_PROD_W-1:0] hi_ff [3];
   logic signed [m3i_pkg::TERM_W-1:0]    term_ff [3];
   logic signed [m3i_pkg::DET_W-1:0]     det_ff, det_in;
   logic signed [m3i_pkg::DQ_W-1:0]      dq_sum, dq;
   logic                                 fits;
   logic signed [m3i_pkg::DETQ_W-1:0]    detq_ff, detq_in, detq2_ff;
   m3i_pkg::det_info_type                info_ff, info_in;
   logic [m3i_pkg::DETQ_W-1:0]           mag;
   logic                                 sing_ff, sing_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            // entry times cofactor, cofactor split in two halves
            lo_ff[r] <= col0[r] * $signed({1'b0, cof0[r][m3i_pkg::COF_LO_W-1:0]});
            hi_ff[r] <= col0[r] * $signed(cof0[r][m3i_pkg::COF_W-1:m3i_pkg::COF_LO_W]);
            term_ff[r] <= (m3i_pkg::TERM_W'(hi_ff[r]) <<< m3i_pkg::COF_LO_W)
                          + m3i_pkg::TERM_W'(lo_ff[r]);
         end
      end
   end

   assign det_in = m3i_pkg::DET_W'(term_ff[0]) + m3i_pkg::DET_W'(term_ff[1])
                   + m3i_pkg::DET_W'(term_ff[2]);

   // round half up to Q32.32, then saturate
   assign dq_sum = m3i_pkg::DQ_W'(det_ff) + DQ_HALF;
   assign dq     = (dq_sum >>> m3i_pkg::SH_R) <<< m3i_pkg::SH_L;
   assign fits   = (&dq[m3i_pkg::DQ_W-1:m3i_pkg::DETQ_W-1])
                   || !(|dq[m3i_pkg::DQ_W-1:m3i_pkg::DETQ_W-1]);

   always_comb begin
      if (fits) begin
         detq_in = dq[m3i_pkg::DETQ_W-1:0];
      end else if (dq[m3i_pkg::DQ_W-1]) begin
         detq_in = {1'b1, {(m3i_pkg::DETQ_W-1){1'b0}}};
      end else begin
         detq_in = {1'b0, {(m3i_pkg::DETQ_W-1){1'b1}}};
      end
      info_in.neg  = det_ff[m3i_pkg::DET_W-1];
      info_in.dabs = det_ff[m3i_pkg::DET_W-1] ? m3i_pkg::DET_W'(-det_ff)
                                               : m3i_pkg::DET_W'(det_ff);
   end

   assign mag     = detq_ff[m3i_pkg::DETQ_W-1] ? (~detq_ff + 1'b1) : detq_ff;
   assign sing_in = mag <= m3i_pkg::DETQ_W'(eps);

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff   <= det_in;
         detq_ff  <= detq_in;
         info_ff  <= info_in;
         detq2_ff <= detq_ff;
         sing_ff  <= sing_in;
      end
   end

   assign info = info_ff;
   assign detq = detq2_ff;
   assign sing = sing_ff;

endmodule

// ===== hw/rtl/m3i_div_lane.sv =====
module m3i_div_lane (
   input  logic                               clock,
   input  logic                               adv,
   input  m3i_pkg::cof_type                   cof,
   input  m3i_pkg::det_info_type              info,
   output logic signed [m3i_pkg::FIELD_W-1:0] inv
);

   localparam int QB = m3i_pkg::QB;

   m3i_pkg::cof_type           cof_dly_ff [m3i_pkg::COF_DLY];
   m3i_pkg::cof_type           c;
   logic [m3i_pkg::MAG_W-1:0]  c_mag;
   logic [m3i_pkg::NUM_W-1:0]  num_ff, num_in, num_hi;
   logic [m3i_pkg::DD_W-1:0]   dd7_ff;
   logic                       neg7_ff;

   logic [m3i_pkg::DD_W-1:0]   rem_ff  [QB+1];
   logic [QB-1:0]              low_ff  [QB+1];
   logic [QB-1:0]              q_ff    [QB+1];
   logic [m3i_pkg::DD_W-1:0]   dd_ff   [QB+1];
   logic                       over_ff [QB+1];
   logic                       neg_ff  [QB+1];

   logic [QB-1:0]              lim, qs, v;
   logic signed [m3i_pkg::FIELD_W-1:0] inv_ff, inv_in;

   // numerator |C| * 2^(2F+1) + |det|, divisor 2*|det|: rounds half away from zero
   assign c      = cof_dly_ff[m3i_pkg::COF_DLY-1];
   assign c_mag  = c[m3i_pkg::COF_W-1] ? m3i_pkg::MAG_W'(-c) : m3i_pkg::MAG_W'(c);
   assign num_in = (m3i_pkg::NUM_W'(c_mag) << m3i_pkg::NUM_SH) + m3i_pkg::NUM_W'(info.dabs);
   assign num_hi = num_ff >> QB;

   always_ff @(posedge clock) begin
      if (adv) begin
         cof_dly_ff[0] <= cof;
         for (int k = 1; k < m3i_pkg::COF_DLY; k++) cof_dly_ff[k] <= cof_dly_ff[k-1];
         num_ff  <= num_in;
         neg7_ff <= c[m3i_pkg::COF_W-1] ^ info.neg;
         dd7_ff  <= {info.dabs, 1'b0};
         // quotient of 2^QB or more saturates anyway
         over_ff[0] <= num_hi >= m3i_pkg::NUM_W'(dd7_ff);
         rem_ff[0]  <= m3i_pkg::DD_W'(num_hi);
         low_ff[0]  <= num_ff[QB-1:0];
         q_ff[0]    <= '0;
         dd_ff[0]   <= dd7_ff;
         neg_ff[0]  <= neg7_ff;
      end
   end

   for (genvar s = 1; s <= QB; s++) begin : g_step
      logic [m3i_pkg::DD_W:0]   t;
      logic                     ge;
      logic [m3i_pkg::DD_W-1:0] r_in;

      always_comb begin
         t    = {rem_ff[s-1], low_ff[s-1][QB-1]};
         ge   = t >= {1'b0, dd_ff[s-1]};
         r_in = ge ? m3i_pkg::DD_W'(t - {1'b0, dd_ff[s-1]}) : m3i_pkg::DD_W'(t);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= r_in;
            low_ff[s]  <= low_ff[s-1] << 1;
            q_ff[s]    <= {q_ff[s-1][QB-2:0], ge};
            dd_ff[s]   <= dd_ff[s-1];
            over_ff[s] <= over_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
         end
      end
   end

   always_comb begin
      lim = (QB'(1) << (m3i_pkg::ENTRY_WIDTH - 1)) - (neg_ff[QB] ? QB'(0) : QB'(1));
      qs  = (over_ff[QB] || q_ff[QB] > lim) ? lim : q_ff[QB];
      v   = neg_ff[QB] ? (~qs + 1'b1) : qs;
      inv_in = m3i_pkg::FIELD_W'($signed(v[m3i_pkg::ENTRY_WIDTH-1:0]));
   end

   always_ff @(posedge clock) begin
      if (adv) inv_ff <= inv_in;
   end

   assign inv = inv_ff;

endmodule

// ===== hw/rtl/matrix3x3_inverse_core.sv =====
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out.
// Input channel req_*: one matrix word per accepted cycle (req_valid high, req_stall low).
// Result channel rsp_*: one word per matrix, in order: nine inverse entries saturated
// to Q16.16, the determinant as saturated Q32.32 and a singular flag. A matrix whose
// Q32.32 determinant magnitude is at or below singular_epsilon gives zero entries.
// Configuration: APB-style port, singular_epsilon at byte address 0, pready always high.
// The divider lanes produce one quotient bit per stage, 33 stages. Throughput is one
// matrix per cycle while the receiver does not stall: nine cofactor lanes, a determinant
// unit and nine divider lanes all run fully pipelined, merged in the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and req_stall is
// raised in the same cycle; items already inside are kept, none are lost.
// Reset clears all valid bits and restores singular_epsilon to 4295.
module matrix3x3_inverse_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  m3i_pkg::req_word_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output m3i_pkg::rsp_word_type             rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [m3i_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [m3i_pkg::EPS_W-1:0]         csr_pwdata,
   output logic [m3i_pkg::EPS_W-1:0]         csr_prdata,
   output logic                              csr_pready
);

   localparam int LAT = m3i_pkg::LATENCY;

   logic                         adv, take;
   logic [LAT-1:0]               vld_ff, vld_in;
   logic [m3i_pkg::EPS_W-1:0]    eps_ff, eps_in;

   m3i_pkg::entry_type           a [3][3];
   m3i_pkg::entry_type           col0_d1_ff [3];
   m3i_pkg::entry_type           col0_d2_ff [3];
   m3i_pkg::cof_type             cofs [3][3];
   m3i_pkg::cof_type             cof0 [3];
   m3i_pkg::det_info_type        info;
   logic signed [m3i_pkg::DETQ_W-1:0] detq;
   logic                         sing;
   logic signed [m3i_pkg::FIELD_W-1:0] inv [9];

   logic signed [m3i_pkg::DETQ_W-1:0] detq_dly_ff [m3i_pkg::SING_DLY];
   logic                         sing_dly_ff [m3i_pkg::SING_DLY];
   m3i_pkg::rsp_word_type        rsp_ff, rsp_in;
   logic                         zsing;

   // pipeline moves unless a finished word is held back
   assign adv       = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;
   assign take      = req_valid && adv;
   assign vld_in    = {vld_ff[LAT-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         eps_ff <= m3i_pkg::EPS_RESET;
      end else begin
         if (adv) vld_ff <= vld_in;
         eps_ff <= eps_in;
      end
   end

   always_comb begin
      eps_in = eps_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr == m3i_pkg::ADDR_EPS) begin
         eps_in = csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == m3i_pkg::ADDR_EPS) ? eps_ff : '0;

   assign a[0][0] = req_data.a00[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[0][1] = req_data.a01[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[0][2] = req_data.a02[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[1][0] = req_data.a10[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[1][1] = req_data.a11[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[1][2] = req_data.a12[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[2][0] = req_data.a20[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[2][1] = req_data.a21[m3i_pkg::ENTRY_WIDTH-1:0];
   assign a[2][2] = req_data.a22[m3i_pkg::ENTRY_WIDTH-1:0];

   for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int R1 = (r == 0) ? 1 : 0;
      localparam int R2 = (r == 2) ? 1 : 2;
      for (genvar c = 0; c < 3; c++) begin : g_col
         localparam int C1 = (c == 0) ? 1 : 0;
         localparam int C2 = (c == 2) ? 1 : 2;
         m3i_cofactor u_cof (
            .clock (clock),
            .adv   (adv),
            .x0    (a[R1][C1]),
            .x1    (a[R2][C2]),
            .y0    (a[R1][C2]),
            .y1    (a[R2][C1]),
            .flip  (((r + c) % 2) == 1),
            .cof   (cofs[r][c])
         );
      end
      assign cof0[r] = cofs[r][0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            col0_d1_ff[r] <= a[r][0];
            col0_d2_ff[r] <= col0_d1_ff[r];
         end
      end
   end

   m3i_det u_det (
      .clock (clock),
      .adv   (adv),
      .col0  (col0_d2_ff),
      .cof0  (cof0),
      .eps   (eps_ff),
      .info  (info),
      .detq  (detq),
      .sing  (sing)
   );

   // inverse (i,j) is cofactor (j,i) over det
   for (genvar i = 0; i < 3; i++) begin : g_ii
      for (genvar j = 0; j < 3; j++) begin : g_jj
         m3i_div_lane u_lane (
            .clock (clock),
            .adv   (adv),
            .cof   (cofs[j][i]),
            .info  (info),
            .inv   (inv[i*3+j])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         detq_dly_ff[0] <= detq;
         sing_dly_ff[0] <= sing;
         for (int k = 1; k < m3i_pkg::SING_DLY; k++) begin
            detq_dly_ff[k] <= detq_dly_ff[k-1];
            sing_dly_ff[k] <= sing_dly_ff[k-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   // merge lanes into the result word
   assign zsing = sing_dly_ff[m3i_pkg::SING_DLY-1];
   always_comb begin
      rsp_in.inv_00      = zsing ? '0 : inv[0];
      rsp_in.inv_01      = zsing ? '0 : inv[1];
      rsp_in.inv_02      = zsing ? '0 : inv[2];
      rsp_in.inv_10      = zsing ? '0 : inv[3];
      rsp_in.inv_11      = zsing ? '0 : inv[4];
      rsp_in.inv_12      = zsing ? '0 : inv[5];
      rsp_in.inv_20      = zsing ? '0 : inv[6];
      rsp_in.inv_21      = zsing ? '0 : inv[7];
      rsp_in.inv_22      = zsing ? '0 : inv[8];
      rsp_in.determinant = detq_dly_ff[m3i_pkg::SING_DLY-1];
      rsp_in.singular    = zsing;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.inv_00 == 0 && rsp_data.inv_11 == 0 && rsp_data.inv_22 == 0
         && rsp_data.inv_01 == 0 && rsp_data.inv_12 == 0 && rsp_data.inv_20 == 0)
      else $error("singular word carries nonzero inverse");

   a_zero_det: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.determinant == 0 |-> rsp_data.singular)
      else $error("zero determinant not flagged singular");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while held");

   a_take: assert property (@(posedge clock) disable iff (reset)
      take |=> vld_ff[0])
      else $error("accepted word lost at entry");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ===== verif/matrix3x3_inverse_core_tb.sv =====
`timescale 1ns / 100ps

module matrix3x3_inverse_core_tb;

   localparam int RW        = $bits(m3i_pkg::rsp_word_type);
   localparam int WD_LIMIT  = 4000;
   localparam int PHASE_LEN = 150;

   typedef logic signed [255:0] wint;

   // inverse predictor and queue of expected result words
   class inverse_ledger;
      m3i_pkg::rsp_word_type pending_inv[$];
      logic [m3i_pkg::EPS_W-1:0] eps_copy;

      function new();
         eps_copy = m3i_pkg::EPS_RESET;
      endfunction

      function wint minor2(input wint m[3][3], input int r, input int c);
         int r1, r2, c1, c2;
         r1 = (r == 0) ? 1 : 0;
         r2 = (r == 2) ? 1 : 2;
         c1 = (c == 0) ? 1 : 0;
         c2 = (c == 2) ? 1 : 2;
         return m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
      endfunction

      function m3i_pkg::rsp_word_type invert(input m3i_pkg::req_word_type w);
         wint a[3][3];
         wint det, dq, mn;
         logic [255:0] dabs, mabs, num, q;
         logic [63:0] detq, mag, lim, qm, v;
         logic fits, sing, neg;
         m3i_pkg::rsp_word_type r;
         a[0][0] = w.a00; a[0][1] = w.a01; a[0][2] = w.a02;
         a[1][0] = w.a10; a[1][1] = w.a11; a[1][2] = w.a12;
         a[2][0] = w.a20; a[2][1] = w.a21; a[2][2] = w.a22;
         det = a[0][0] * minor2(a, 0, 0) - a[1][0] * minor2(a, 1, 0)
             + a[2][0] * minor2(a, 2, 0);
         if (m3i_pkg::DQ_SHIFT > 0)
            dq = (det + (wint'(1) <<< (m3i_pkg::SH_R - 1))) >>> m3i_pkg::SH_R;
         else dq = det <<< m3i_pkg::SH_L;
         fits = (dq[255:63] == '0) || (&dq[255:63]);
         if (fits) detq = dq[63:0];
         else detq = dq[255] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         mag  = detq[63] ? -detq : detq;
         sing = mag <= {32'd0, eps_copy};
         dabs = det[255] ? -det : det;
         r = '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               v = '0;
               if (!sing) begin
                  mn = minor2(a, j, i);
                  if ((i + j) % 2) mn = -mn;
                  neg  = mn[255] != det[255];
                  mabs = mn[255] ? -mn : mn;
                  num  = (mabs << m3i_pkg::NUM_SH) + dabs;
                  q    = num / (dabs << 1);
                  lim  = (64'd1 << (m3i_pkg::ENTRY_WIDTH - 1)) - (neg ? 64'd0 : 64'd1);
                  qm   = (q > {192'd0, lim}) ? lim : q[63:0];
                  v    = neg ? -qm : qm;
               end
               r[RW-1-32*(3*i+j) -: 32] = v[31:0];
            end
         end
         r.determinant = detq;
         r.singular    = sing;
         return r;
      endfunction

      function void note_matrix(input m3i_pkg::req_word_type w);
         pending_inv.push_back(invert(w));
      endfunction

      // returns a description of the mismatching fields, empty when all agree
      function string check_result(input m3i_pkg::rsp_word_type got);
         m3i_pkg::rsp_word_type want;
         string diffs;
         diffs = "";
         want = pending_inv.pop_front();
         for (int k = 0; k < 9; k++) begin
            if (got[RW-1-32*k -: 32] !== want[RW-1-32*k -: 32])
               diffs = {diffs, $sformatf(" inv_%0d%0d got %h want %h", k / 3, k % 3,
                        got[RW-1-32*k -: 32], want[RW-1-32*k -: 32])};
         end
         if (got.determinant !== want.determinant)
            diffs = {diffs, $sformatf(" determinant got %h want %h",
                     got.determinant, want.determinant)};
         if (got.singular !== want.singular)
            diffs = {diffs, $sformatf(" singular got %b want %b", got.singular,
                     want.singular)};
         return diffs;
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   m3i_pkg::req_word_type req_data;
   m3i_pkg::rsp_word_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [m3i_pkg::CSR_AW-1:0] csr_paddr;
   logic [m3i_pkg::EPS_W-1:0] csr_pwdata, csr_prdata;

   inverse_ledger ledger = new();
   int errors = 0;
   int tx_idle_pct = 0, rx_idle_pct = 0;
   int wd_count = 0;
   int n_words = 0, n_results = 0, n_singular = 0;

   matrix3x3_inverse_core DUT (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at %0t:%s", $time, what);
   endtask

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      string d;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) wd_count = 0;
         else wd_count++;
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (rsp_data.singular) n_singular++;
            if (ledger.pending_inv.size() == 0) report(" result word with none expected");
            else begin
               d = ledger.check_result(rsp_data);
               if (d != "") report(d);
            end
         end
         if (wd_count >= WD_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
            $display("[matrix3x3_inverse_core] ERROR");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_matrix(input m3i_pkg::req_word_type w);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (req_stall);
      ledger.note_matrix(w);
      n_words++;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [m3i_pkg::CSR_AW-1:0] addr,
                            input logic [m3i_pkg::EPS_W-1:0] val);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = addr;
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      ledger.eps_copy = val;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (ledger.pending_inv.size() != 0) @(negedge clock);
      repeat (m3i_pkg::LATENCY + 5) @(negedge clock);
   endtask

   function automatic m3i_pkg::req_word_type mk(input logic [31:0] e0, e1, e2, e3, e4,
                                                e5, e6, e7, e8);
      return {e0, e1, e2, e3, e4, e5, e6, e7, e8};
   endfunction

   function automatic logic [31:0] small_q();
      return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
   endfunction

   function automatic m3i_pkg::req_word_type rand_matrix();
      logic [31:0] e[9];
      int kind, s;
      kind = $urandom_range(99);
      foreach (e[k]) e[k] = small_q();
      if (kind < 25) begin
         foreach (e[k]) e[k] = $urandom();
      end else if (kind < 40) begin
         // singular: one row copies another or is a multiple
         s = $urandom_range(2);
         for (int c = 0; c < 3; c++) e[3*((s+1)%3)+c] = (kind < 33) ? e[3*s+c] : -e[3*s+c];
      end else if (kind < 50) begin
         // tiny entries, determinant close to the threshold
         foreach (e[k]) e[k] = 32'($signed($urandom_range(0, 32'h1000)) - 32'sh800);
      end else if (kind < 60) begin
         foreach (e[k]) e[k] = 32'd0;
         e[0] = small_q(); e[4] = small_q(); e[8] = $urandom_range(1, 32'h40);
         if ($urandom_range(1)) e[8] = -e[8];
      end else if (kind < 70) begin
         foreach (e[k]) if ($urandom_range(3) == 0) e[k] = $urandom();
      end
      return mk(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
   endfunction

   initial begin
      logic [m3i_pkg::EPS_W-1:0] eps_list[5];
      int ep;
      eps_list = '{32'd0, 32'hFFFF_FFFF, 32'd4295, 32'd1, 32'd0};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = m3i_pkg::ADDR_EPS;
      csr_pwdata  = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed words at the reset threshold
      send_matrix(mk(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
      send_matrix('0);
      send_matrix({9{32'h7FFF_FFFF}});
      send_matrix({9{32'h8000_0000}});
      send_matrix(mk(32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000));
      send_matrix(mk(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000));
      send_matrix(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(mk(32'h100, 0, 0, 0, 32'h100, 0, 0, 0, 32'h100));
      send_matrix(mk(32'h20000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h30000));
      send_matrix(mk(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 1));
      send_matrix(mk(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'hFFFF_FFFF));
      send_matrix(mk(0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0));
      send_matrix(mk(32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
                     32'h70000, 32'h80000, 32'hA0000));
      send_matrix(mk(32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000,
                     32'h70000, 32'h80000, 32'h90000));
      send_matrix(mk(32'hFFFF_0000, 32'h5, 32'h7FFF_FFFF, 32'h8000_0001, 32'h3,
                     32'hFFFF_FFFF, 32'h2, 32'h8000_0000, 32'h10000));

      ep = 0;
      for (int p = 0; p < 3; p++) begin
         tx_idle_pct = (p == 0) ? 14 : (p == 1) ? 53 : 0;
         rx_idle_pct = (p == 0) ? 53 : (p == 1) ? 14 : 0;
         for (int b = 0; b < 3; b++) begin
            drain();
            csr_write(m3i_pkg::ADDR_EPS, (ep < 5) ? eps_list[ep] : $urandom());
            ep++;
            for (int n = 0; n < PHASE_LEN; n++) begin
               send_matrix(rand_matrix());
            end
         end
      end

      req_valid = 1'b0;
      while (ledger.pending_inv.size() != 0) @(negedge clock);
      repeat (m3i_pkg::LATENCY + 10) @(negedge clock);

      $display("covered %0d matrix words, %0d result words, %0d flagged singular",
               n_words, n_results, n_singular);
      $display("thresholds swept from 0 to all ones under three stall patterns");
      if (errors == 0) $display("[matrix3x3_inverse_core] OK");
      else $display("[matrix3x3_inverse_core] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_cofactor.sv
hw/rtl/m3i_det.sv
hw/rtl/m3i_div_lane.sv
hw/rtl/matrix3x3_inverse_core.sv
verif/matrix3x3_inverse_core_tb.sv
